// ===== sv/paged_bitmap_block_allocator_defines.svh =====
// assertion macros for the paged bitmap block allocator
// used by the modules that carry concurrent checks
`ifndef PAGED_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define PAGED_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define PBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PBA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PBA_ASSERT(label, clk, rst_n, prop)
`define PBA_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/pba_pkg.sv =====
// shared types and constants for the paged bitmap block allocator
// no dependencies
`timescale 1ns / 1ps
package pba_pkg;
  localparam int unsigned NumBlocksDef = 16;
  localparam int unsigned MaxPagesDef  = 64;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StZero      = 2'd1;
  localparam logic [1:0] StTooLarge  = 2'd2;
  localparam logic [1:0] StExhausted = 2'd3;

  localparam logic CfgPageSizeLog2 = 1'b0;
  localparam logic CfgPagesPerBlk  = 1'b1;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] size_bytes;
    logic [3:0]  rel_block;
    logic [5:0]  free_page;
    logic [6:0]  free_pages;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] grant_block;
    logic [5:0] grant_page;
    logic [6:0] grant_pages;
    logic       block_returned;
  } rsp_t;

  typedef struct packed {
    logic       start;
    logic [6:0] n;
    logic [6:0] ppb;
  } scan_req_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [5:0] page;
  } scan_rsp_t;
endpackage

// ===== sv/paged_bitmap_block_allocator.sv =====
// paged bitmap block allocator: first-fit page runs over a pool of blocks
// allocate: size check, then each listed block from the head is scanned for a first-fit run;
// if none fits, a fresh block is popped from the free stack and linked, full-block runs at the tail;
// size errors and an empty free stack give an error status; free clears pages of a listed block,
// else is ignored; one item at a time, next accept after the result leaves
// reset: list empty, all blocks on the free stack with block 0 on top, config at defaults
// depends on pba_pkg and pba_scan
`timescale 1ns / 1ps
`include "paged_bitmap_block_allocator_defines.svh"
module paged_bitmap_block_allocator #(
  parameter int unsigned NumBlocks = pba_pkg::NumBlocksDef,
  parameter int unsigned MaxPages  = pba_pkg::MaxPagesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pba_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pba_pkg::rsp_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  localparam int unsigned BW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned LW = $clog2(NumBlocks + 1);
  localparam logic [LW-1:0] None = LW'(NumBlocks);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SIZE  = 9'b000000010,
    S_WALK  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_POP   = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_FREE  = 9'b001000000,
    S_RELK  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] psl_q;
  logic [6:0] ppb_q;
  logic [MaxPages-1:0] bm_q [NumBlocks];
  logic [LW-1:0] nxt_q [NumBlocks];
  logic [LW-1:0] prv_q [NumBlocks];
  logic [NumBlocks-1:0] inl_q;
  logic [BW-1:0] stk_q [NumBlocks];
  logic [LW-1:0] head_q, tail_q, cnt_q;
  pba_pkg::req_t req_q;
  pba_pkg::rsp_t rsp_q;
  logic [LW-1:0] cur_q;
  logic [LW-1:0] steps_q;
  logic [6:0]    n_q;
  logic          out_v_q;

  logic [6:0] ppb_eff;
  logic [32:0] rnd;
  logic [32:0] pages;
  pba_pkg::scan_req_t sreq;
  pba_pkg::scan_rsp_t srsp;
  logic [MaxPages-1:0] cur_bm, span0, fmask;
  logic [BW-1:0] cb, fbk;
  logic [7:0] fend;

  assign ppb_eff = (ppb_q == '0) ? 7'd1 :
                   (ppb_q > 7'(MaxPages)) ? 7'(MaxPages) : ppb_q;
  // round up: add unit minus one, then shift
  assign rnd   = {1'b0, req_q.size_bytes} + ((33'd1 << psl_q) - 33'd1);
  assign pages = rnd >> psl_q;
  assign cb     = cur_q[BW-1:0];
  assign cur_bm = bm_q[cb];
  assign fbk    = req_q.rel_block[BW-1:0];
  assign fend   = ({2'b0, req_q.free_page} + {1'b0, req_q.free_pages} > 8'(MaxPages)) ?
                  8'(MaxPages) : {2'b0, req_q.free_page} + {1'b0, req_q.free_pages};

  always_comb begin
    span0 = '0;
    fmask = '0;
    for (int i = 0; i < MaxPages; i++) begin
      if (i < int'(n_q)) span0[i] = 1'b1;
      if (i >= int'(req_q.free_page) && i < int'(fend)) fmask[i] = 1'b1;
    end
  end

  assign sreq.start = (state_q == S_WALK) && (cur_q < None) && (steps_q < None);
  assign sreq.n     = n_q;
  assign sreq.ppb   = ppb_eff;

  pba_scan #(.MaxPages(MaxPages)) u_scan (
    .clk_i, .rst_ni, .req_i(sreq), .bitmap_i(cur_bm), .rsp_o(srsp)
  );

  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = (in_data_i.mode == pba_pkg::ModeFree) ? S_FREE : S_SIZE;
        end
      end
      S_SIZE: begin
        if (req_q.size_bytes == '0 || pages > {26'd0, ppb_eff}) state_d = S_OUT;
        else state_d = S_WALK;
      end
      S_WALK: state_d = sreq.start ? S_SCAN : S_POP;
      S_SCAN: if (srsp.done) state_d = srsp.found ? S_OUT : S_WALK;
      S_POP:  state_d = (cnt_q == '0) ? S_OUT : S_LINK;
      S_LINK: state_d = S_OUT;
      S_FREE: begin
        if (32'(req_q.rel_block) >= NumBlocks || !inl_q[fbk]) state_d = S_OUT;
        else state_d = S_RELK;
      end
      S_RELK: state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      psl_q   <= 5'd12;
      ppb_q   <= 7'd64;
      head_q  <= None;
      tail_q  <= None;
      cnt_q   <= LW'(NumBlocks);
      inl_q   <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < NumBlocks; i++) stk_q[i] <= BW'(NumBlocks - 1 - i);
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pba_pkg::CfgPageSizeLog2: psl_q <= cfg_data_i[4:0];
          pba_pkg::CfgPagesPerBlk:  ppb_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT) out_v_q <= 1'b1;
      else if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      // pop and link a fresh block
      if (state_q == S_LINK) begin
        cnt_q <= cnt_q - 1'b1;
        inl_q[stk_q[cnt_q[BW-1:0] - 1'b1]] <= 1'b1;
        if (n_q == ppb_eff) begin
          if (tail_q == None) head_q <= LW'(stk_q[cnt_q[BW-1:0] - 1'b1]);
          tail_q <= LW'(stk_q[cnt_q[BW-1:0] - 1'b1]);
        end else begin
          if (head_q == None) tail_q <= LW'(stk_q[cnt_q[BW-1:0] - 1'b1]);
          head_q <= LW'(stk_q[cnt_q[BW-1:0] - 1'b1]);
        end
      end
      // unlink, then push back or relink at head
      if (state_q == S_RELK) begin
        if ((bm_q[fbk] & ~fmask) == '0) begin
          inl_q[fbk] <= 1'b0;
          stk_q[cnt_q[BW-1:0]] <= fbk;
          cnt_q <= cnt_q + 1'b1;
          if (nxt_q[fbk] == None) tail_q <= prv_q[fbk];
          if (prv_q[fbk] == None) head_q <= nxt_q[fbk];
        end else if (prv_q[fbk] != None) begin
          head_q <= LW'(fbk);
          if (nxt_q[fbk] == None) tail_q <= prv_q[fbk];
        end
      end
    end
  end

  // datapath: request, walk pointer, stores, result
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_ready_o) begin
          req_q   <= in_data_i;
          rsp_q   <= '0;
          cur_q   <= head_q;
          steps_q <= '0;
        end
      end
      S_SIZE: begin
        n_q <= pages[6:0];
        if (req_q.size_bytes == '0) rsp_q.status <= pba_pkg::StZero;
        else if (pages > {26'd0, ppb_eff}) rsp_q.status <= pba_pkg::StTooLarge;
      end
      S_SCAN: begin
        if (srsp.done && srsp.found) begin
          bm_q[cb] <= cur_bm | (span0 << srsp.page);
          rsp_q.grant_block <= 4'(cb);
          rsp_q.grant_page  <= srsp.page;
          rsp_q.grant_pages <= n_q;
        end else if (srsp.done) begin
          cur_q   <= nxt_q[cb];
          steps_q <= steps_q + 1'b1;
        end
      end
      S_POP: if (cnt_q == '0) rsp_q.status <= pba_pkg::StExhausted;
      S_LINK: begin
        bm_q[stk_q[cnt_q[BW-1:0] - 1'b1]] <= span0;
        rsp_q.grant_block <= 4'(stk_q[cnt_q[BW-1:0] - 1'b1]);
        rsp_q.grant_pages <= n_q;
        if (n_q == ppb_eff) begin
          nxt_q[stk_q[cnt_q[BW-1:0] - 1'b1]] <= None;
          prv_q[stk_q[cnt_q[BW-1:0] - 1'b1]] <= tail_q;
          if (tail_q != None) nxt_q[tail_q[BW-1:0]] <= LW'(stk_q[cnt_q[BW-1:0] - 1'b1]);
        end else begin
          prv_q[stk_q[cnt_q[BW-1:0] - 1'b1]] <= None;
          nxt_q[stk_q[cnt_q[BW-1:0] - 1'b1]] <= head_q;
          if (head_q != None) prv_q[head_q[BW-1:0]] <= LW'(stk_q[cnt_q[BW-1:0] - 1'b1]);
        end
      end
      S_RELK: begin
        bm_q[fbk] <= bm_q[fbk] & ~fmask;
        if ((bm_q[fbk] & ~fmask) == '0) begin
          rsp_q.block_returned <= 1'b1;
          if (nxt_q[fbk] != None) prv_q[nxt_q[fbk][BW-1:0]] <= prv_q[fbk];
          if (prv_q[fbk] != None) nxt_q[prv_q[fbk][BW-1:0]] <= nxt_q[fbk];
        end else if (prv_q[fbk] != None) begin
          // move from the middle or tail to the head
          nxt_q[prv_q[fbk][BW-1:0]] <= nxt_q[fbk];
          if (nxt_q[fbk] != None) prv_q[nxt_q[fbk][BW-1:0]] <= prv_q[fbk];
          prv_q[fbk] <= None;
          nxt_q[fbk] <= head_q;
          prv_q[head_q[BW-1:0]] <= LW'(fbk);
        end
      end
      default: ;
    endcase
  end

  `PBA_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !in_ready_o)
  `PBA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= LW'(NumBlocks))
  `PBA_ASSERT(a_out_after, clk_i, rst_ni, (state_q == S_OUT) |=> out_valid_o)
  `PBA_ASSERT(a_link_nonempty, clk_i, rst_ni, (state_q == S_LINK) |-> (cnt_q != '0))
endmodule

// ===== sv/pba_scan.sv =====
// first-fit run search over one page bitmap, one start position per cycle
// depends on pba_pkg
`timescale 1ns / 1ps
`include "paged_bitmap_block_allocator_defines.svh"
module pba_scan #(
  parameter int unsigned MaxPages = pba_pkg::MaxPagesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pba_pkg::scan_req_t  req_i,
  input  logic [MaxPages-1:0] bitmap_i,
  output pba_pkg::scan_rsp_t  rsp_o
);
  localparam int unsigned PW = $clog2(MaxPages + 1);

  logic          busy_q, busy_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [MaxPages-1:0] mask_q, mask_d;
  logic [PW:0]   end_sum;
  logic          fits, hit;

  // run end against block size; shared mask shifter
  assign end_sum = {1'b0, pos_q} + {1'b0, req_i.n[PW-1:0]};
  assign fits    = end_sum <= {1'b0, req_i.ppb[PW-1:0]};
  assign hit     = fits && ((bitmap_i & mask_q) == '0);

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    mask_d = mask_q;
    rsp_o  = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      pos_d  = '0;
      mask_d = '0;
      for (int i = 0; i < MaxPages; i++) begin
        if (i < int'(req_i.n)) mask_d[i] = 1'b1;
      end
    end else if (busy_q) begin
      if (hit || !fits) begin
        busy_d       = 1'b0;
        rsp_o.done   = 1'b1;
        rsp_o.found  = hit;
        rsp_o.page   = 6'(pos_q);
      end else begin
        pos_d  = pos_q + 1'b1;
        mask_d = mask_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    mask_q <= mask_d;
  end

  `PBA_ASSERT(a_done_busy, clk_i, rst_ni, rsp_o.done |-> busy_q)
  `PBA_ASSERT(a_found_fits, clk_i, rst_ni, rsp_o.found |-> fits)
  `PBA_ASSERT(a_done_idle, clk_i, rst_ni, rsp_o.done |=> !busy_q)
endmodule

// ===== test/testbench.sv =====
// self-checking testbench for paged_bitmap_block_allocator
// depends on pba_pkg and the allocator rtl; predicts every result in the bench
`timescale 1ns / 1ps
module testbench;
  localparam int NBLK = 16;
  localparam int MAXP = 64;
  localparam int NONE = NBLK;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;
  pba_pkg::req_t in_data_i;
  pba_pkg::rsp_t out_data_o;

  paged_bitmap_block_allocator dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // allocator state mirror
  logic [4:0]  psz_log2;
  logic [6:0]  ppb_reg;
  logic [63:0] bitmap [NBLK];
  int          nxt [NBLK];
  int          prv [NBLK];
  bit          listed [NBLK];
  int          head, tail;
  int          free_stk [NBLK];
  int          free_cnt;

  pba_pkg::rsp_t expected_rsp [$];
  pba_pkg::rsp_t last_pred;
  int   err_cnt;
  int   mismatch_cnt;

  // live grants that may be freed later
  typedef struct { int blk; int pg; int n; } grant_t;
  grant_t live [$];

  function automatic logic [63:0] span(int s, int n);
    if (n >= 64) return '1;
    return ((64'd1 << n) - 64'd1) << s;
  endfunction

  function automatic void link_front(int b);
    prv[b] = NONE; nxt[b] = head;
    if (head != NONE) prv[head] = b; else tail = b;
    head = b; listed[b] = 1;
  endfunction

  function automatic void link_back(int b);
    nxt[b] = NONE; prv[b] = tail;
    if (tail != NONE) nxt[tail] = b; else head = b;
    tail = b; listed[b] = 1;
  endfunction

  function automatic void unlink(int b);
    int n, p;
    n = nxt[b]; p = prv[b];
    if (n != NONE) prv[n] = p; else tail = p;
    if (p != NONE) nxt[p] = n; else head = n;
    nxt[b] = NONE; prv[b] = NONE; listed[b] = 0;
  endfunction

  function automatic void reset_mirror();
    psz_log2 = 5'd12; ppb_reg = 7'd64;
    head = NONE; tail = NONE; free_cnt = NBLK;
    for (int i = 0; i < NBLK; i++) begin
      bitmap[i] = '0; nxt[i] = 0; prv[i] = 0; listed[i] = 0;
      free_stk[i] = NBLK - 1 - i;
    end
  endfunction

  // predict the result of one request and update the mirror
  function automatic pba_pkg::rsp_t predict_alloc_result(pba_pkg::req_t r);
    pba_pkg::rsp_t o;
    int ppb, n, b, steps, e;
    logic [63:0] pages, unit;
    o = '0;
    if (r.mode == pba_pkg::ModeAlloc) begin
      ppb = (ppb_reg == 0) ? 1 : (ppb_reg > MAXP ? MAXP : int'(ppb_reg));
      unit = 64'd1 << psz_log2;
      pages = (64'(r.size_bytes) + unit - 64'd1) >> psz_log2;
      if (r.size_bytes == 0) begin o.status = pba_pkg::StZero; return o; end
      if (pages > 64'(ppb)) begin o.status = pba_pkg::StTooLarge; return o; end
      n = int'(pages);
      b = head;
      for (steps = 0; steps < NBLK && b < NBLK; steps++) begin
        for (int s = 0; s + n <= ppb; s++) begin
          if ((bitmap[b] & span(s, n)) == 0) begin
            bitmap[b] |= span(s, n);
            o.grant_block = 4'(b); o.grant_page = 6'(s); o.grant_pages = 7'(n);
            live.push_back('{b, s, n});
            return o;
          end
        end
        b = nxt[b];
      end
      if (free_cnt == 0) begin o.status = pba_pkg::StExhausted; return o; end
      free_cnt--;
      b = free_stk[free_cnt];
      bitmap[b] = '0;
      if (n == ppb) link_back(b); else link_front(b);
      bitmap[b] |= span(0, n);
      o.grant_block = 4'(b); o.grant_page = '0; o.grant_pages = 7'(n);
      live.push_back('{b, 0, n});
    end else begin
      b = int'(r.rel_block);
      if (!listed[b]) return o;
      e = r.free_page + r.free_pages;
      if (e > MAXP) e = MAXP;
      if (e > r.free_page) bitmap[b] &= ~span(r.free_page, e - r.free_page);
      unlink(b);
      if (bitmap[b] == 0) begin
        if (free_cnt < NBLK) begin free_stk[free_cnt] = b; free_cnt++; end
        o.block_returned = 1'b1;
      end else begin
        link_front(b);
      end
    end
    return o;
  endfunction

  function automatic pba_pkg::req_t mk_alloc(logic [31:0] sz);
    pba_pkg::req_t r;
    r = '0; r.mode = pba_pkg::ModeAlloc; r.size_bytes = sz;
    r.rel_block = 4'($urandom); r.free_page = 6'($urandom); r.free_pages = 7'($urandom);
    return r;
  endfunction

  function automatic pba_pkg::req_t mk_free(int b, int p, int n);
    pba_pkg::req_t r;
    r.mode = pba_pkg::ModeFree; r.size_bytes = $urandom;
    r.rel_block = 4'(b); r.free_page = 6'(p); r.free_pages = 7'(n);
    return r;
  endfunction

  // sender side
  int gap_len, burst_left;

  task automatic send_req(pba_pkg::req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      repeat (gap_len) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    last_pred = predict_alloc_result(r);
    expected_rsp.push_back(last_pred);
    in_valid_i <= 1'b0;
    in_data_i  <= mk_alloc($urandom);
    // the block is never ready the cycle after an accept
    @(posedge clk_i);
  endtask

  // send and check against a typed-in value as well
  task automatic send_known(pba_pkg::req_t r, pba_pkg::rsp_t want);
    send_req(r);
    if (last_pred != want) begin
      err_cnt++;
      if (mismatch_cnt++ < 10)
        $display("directed row mismatch: typed %h predicted %h", want, last_pred);
    end
  endtask

  task automatic wait_drain();
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == pba_pkg::CfgPageSizeLog2) psz_log2 = val[4:0]; else ppb_reg = val[6:0];
    @(posedge clk_i);
  endtask

  // free a live grant, sometimes mangled, or now and then a random block
  function automatic pba_pkg::req_t pick_free();
    grant_t g;
    int k;
    if (live.size() == 0 || $urandom_range(0, 9) == 0)
      return mk_free($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 127));
    k = $urandom_range(0, live.size() - 1);
    g = live[k];
    live.delete(k);
    if ($urandom_range(0, 7) == 0) g.n = $urandom_range(0, 127);
    return mk_free(g.blk, g.pg, g.n);
  endfunction

  function automatic logic [31:0] rand_size(int ppb);
    int n;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: begin
        n = (ppb == 0) ? 1 : $urandom_range(1, ppb);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 3);
        return (32'(n - 1) << psz_log2) + 32'($urandom_range(1, 1 << psz_log2));
      end
    endcase
  endfunction

  // receiver stall pattern, with one long hold-off
  bit long_hold;
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end
      case ($urandom_range(0, 3))
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'b0;
        default: out_ready_i <= $urandom_range(0, 2) != 0;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp.size() == 0) begin
        err_cnt++;
        if (mismatch_cnt++ < 10) $display("unexpected result %h", out_data_o);
      end else begin
        pba_pkg::rsp_t w;
        w = expected_rsp.pop_front();
        if (w != out_data_o) begin
          err_cnt++;
          if (mismatch_cnt++ < 10)
            $display("mismatch: exp st=%0d blk=%0d pg=%0d n=%0d ret=%0b %s",
              w.status, w.grant_block, w.grant_page, w.grant_pages, w.block_returned,
              $sformatf("got st=%0d blk=%0d pg=%0d n=%0d ret=%0b",
                out_data_o.status, out_data_o.grant_block, out_data_o.grant_page,
                out_data_o.grant_pages, out_data_o.block_returned));
        end
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

  // main sequence
  typedef struct { pba_pkg::req_t r; bit known; pba_pkg::rsp_t want; } row_t;
  row_t rows [$];
  pba_pkg::rsp_t z;
  initial begin
    pba_pkg::rsp_t g;
    int ppb;
    err_cnt = 0; mismatch_cnt = 0; burst_left = 0; long_hold = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    reset_mirror();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    z = '0;
    g = z; g.status = pba_pkg::StZero;
    rows.push_back('{mk_alloc(32'd0), 1, g});
    g = z; g.status = pba_pkg::StTooLarge;
    rows.push_back('{mk_alloc(32'hFFFF_FFFF), 1, g});
    g = z; g.grant_block = 4'd0; g.grant_pages = 7'd1;
    rows.push_back('{mk_alloc(32'd1), 1, g});
    g = z; g.grant_block = 4'd1; g.grant_pages = 7'd64;
    rows.push_back('{mk_alloc(32'd262144), 1, g});
    rows.push_back('{mk_alloc(32'd4097), 0, z});
    rows.push_back('{mk_free(15, 0, 1), 1, z});
    rows.push_back('{mk_free(0, 0, 1), 0, z});
    rows.push_back('{mk_free(0, 63, 127), 0, z});
    rows.push_back('{mk_free(1, 0, 0), 0, z});
    rows.push_back('{mk_free(1, 0, 127), 0, z});
    for (int i = 0; i < 17; i++) rows.push_back('{mk_alloc(32'd262144), 0, z});
    foreach (rows[i]) begin
      if (rows[i].known) send_known(rows[i].r, rows[i].want);
      else send_req(rows[i].r);
    end
    wait_drain();
    for (int i = 0; i < NBLK; i++) send_req(mk_free(i, 0, 64));

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      wait_drain();
      case (ph)
        0: begin
          write_cfg(pba_pkg::CfgPageSizeLog2, 32'd0);
          write_cfg(pba_pkg::CfgPagesPerBlk, 32'd8);
        end
        1: begin
          write_cfg(pba_pkg::CfgPageSizeLog2, 32'd24);
          write_cfg(pba_pkg::CfgPagesPerBlk, 32'd64);
        end
        2: begin
          write_cfg(pba_pkg::CfgPageSizeLog2, 32'd31);
          write_cfg(pba_pkg::CfgPagesPerBlk, 32'd0);
        end
        3: begin
          write_cfg(pba_pkg::CfgPageSizeLog2, 32'd3);
          write_cfg(pba_pkg::CfgPagesPerBlk, 32'd127);
        end
        4: begin
          write_cfg(pba_pkg::CfgPageSizeLog2, $urandom);
          write_cfg(pba_pkg::CfgPagesPerBlk, 32'd5);
        end
        default: begin
          write_cfg(pba_pkg::CfgPageSizeLog2, 32'd12);
          write_cfg(pba_pkg::CfgPagesPerBlk, 32'd16);
        end
      endcase
      ppb = (ppb_reg == 0) ? 1 : (ppb_reg > MAXP ? MAXP : int'(ppb_reg));
      if (ph == 1) long_hold = 1;
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 99) < 55) send_req(mk_alloc(rand_size(ppb)));
        else send_req(pick_free());
      end
    end

    wait_drain();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && expected_rsp.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/pba_pkg.sv
sv/pba_scan.sv
sv/paged_bitmap_block_allocator.sv
test/testbench.sv
